// File: hw/rtl/chr_tile_to_bitmap_converter_macros.svh
// Assertion macros shared by the tile-to-bitmap converter RTL.
`ifndef CHR_TILE_TO_BITMAP_CONVERTER_MACROS_SVH
`define CHR_TILE_TO_BITMAP_CONVERTER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CTBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CTBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ctbc_pkg.sv
// Shared types and constants for the tile-to-bitmap converter.
package ctbc_pkg;

  localparam int ROW_W = 12;    // address inside one bank of the pattern store
  localparam int BYTE_W = 8;
  localparam int SEL_W = 2;     // which pixel pair inside a plane byte

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Request presented to the pattern store stage.
  typedef struct packed {
    logic              valid;
    logic              load;
    logic              bank;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] data;
    logic [SEL_W-1:0]  pair_sel;
    logic              blank;
  } mem_req_t;

  // Plane bytes returned by the pattern store stage for a read beat.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] plane0;
    logic [BYTE_W-1:0] plane1;
    logic [SEL_W-1:0]  pair_sel;
    logic              blank;
  } rd_data_t;

endpackage

// File: hw/rtl/chr_tile_to_bitmap_converter.sv
// Top level of the pattern tile to 4-bit-per-pixel bitmap converter.
//
// The block holds two pattern tables of 8x8 two-plane tiles (8 KiB) and turns
// them into bytes of a bottom-up 4-bit-per-pixel bitmap that shows table 0
// above table 1, LINE_TILES tiles per line. Each input beat is either a load
// (func = 0), which writes src_byte into the store at src_addr and produces no
// output beat, or a read (func = 1), which produces one output beat holding the
// two pixels of bitmap byte out_index: bits 5:4 the left pixel and bits 1:0 the
// right one, each as {plane-0 bit, plane-1 bit}. A read whose line lies beyond
// the image returns zero. Reading a store byte that was never loaded returns
// an undefined value, so load every byte that a read will touch first.
// The block takes one beat per clock cycle while in_stall is low, loads and
// reads mixed freely. The rate rests on the store being split into two banks
// on address bit 3: the plane-0 byte of a pixel row lives in one bank and its
// plane-1 byte in the other, so each bank does one read and at most one write
// per cycle. The line number is found by a multiply with a reciprocal and one
// correction step, followed by the table split, the tile address, the store
// read and the pixel assembly, each in its own register stage. An output
// register and a skid register sit at the end, so in_stall is a register and
// never waits on out_stall within the same cycle. A load followed by a read of
// the same byte returns the new byte, since the store sees beats strictly in
// order.
module chr_tile_to_bitmap_converter
  import ctbc_pkg::*;
#(
  parameter int LINE_TILES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [12:0] src_addr,
  input  logic [7:0]  src_byte,
  input  logic [13:0] out_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_pair
);

  mem_req_t req;
  rd_data_t rd;
  logic     hold;
  logic     en;

  // The whole pipeline advances together unless the skid register is full.
  assign en = !hold;
  assign in_stall = hold;

  ctbc_addr_gen #(
    .LINE_TILES(LINE_TILES)
  ) u_addr_gen (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(in_valid),
    .func(func),
    .src_addr(src_addr),
    .src_byte(src_byte),
    .out_index(out_index),
    .req(req)
  );

  ctbc_store u_store (
    .clk(clk),
    .rst(rst),
    .en(en),
    .req(req),
    .rd(rd)
  );

  ctbc_out_buf u_out_buf (
    .clk(clk),
    .rst(rst),
    .en(en),
    .rd(rd),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .pixel_pair(pixel_pair),
    .hold(hold)
  );

endmodule

// File: hw/rtl/ctbc_addr_gen.sv
// Four-stage address pipeline: bitmap byte index to pattern store row.
module ctbc_addr_gen
  import ctbc_pkg::*;
#(
  parameter int LINE_TILES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic         func,
  input  logic [12:0]  src_addr,
  input  logic [7:0]   src_byte,
  input  logic [13:0]  out_index,
  output mem_req_t     req
);

  localparam int IDX_W = 14;
  localparam int LINE_BYTES = LINE_TILES * 4;
  localparam int TABLE_LINES = 8 * (256 / LINE_TILES);
  localparam int TOTAL_LINES = 2 * TABLE_LINES;
  localparam int DIV_SHIFT = 14;
  localparam int RECIP = (1 << DIV_SHIFT) / LINE_BYTES;
  localparam int LINE_W = IDX_W - 3;
  localparam int LB_W = $clog2(LINE_BYTES);
  localparam int R_W = 10;
  localparam int PROD_W = 2 * IDX_W;

  // Load fields ride along with the read fields through every stage.
  logic              v1, v2, v3, v4;
  logic              ld1, ld2, ld3, ld4;
  logic [12:0]       sa1, sa2, sa3;
  logic [7:0]        sb1, sb2, sb3, sb4;

  // Stage 1: estimated line number.
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  o1;
  logic [LINE_W-1:0] qest;

  // Stage 2: exact line and byte position within the line.
  logic [IDX_W-1:0]  qd;
  logic [IDX_W-1:0]  rem_full;
  logic [LB_W:0]     rem;
  logic [LINE_W-1:0] line_next;
  logic [LB_W-1:0]   in_line_next;
  logic [LINE_W-1:0] line;
  logic [LB_W-1:0]   in_line2;

  // Stage 3: table and row inside the table.
  logic [LINE_W-1:0] y;
  logic              past_next;
  logic              table_next;
  logic [R_W-1:0]    r_next;
  logic              past3;
  logic              tbl3;
  logic [R_W-1:0]    r3;
  logic [LB_W-1:0]   in_line3;

  // Stage 4: store row.
  logic [IDX_W-1:0]  tile_sum;
  logic [ROW_W-1:0]  row4;
  logic              bank4;
  logic [SEL_W-1:0]  sel4;
  logic              blank4;

  assign prod = PROD_W'(out_index) * PROD_W'(RECIP);

  always_comb begin
    qd = IDX_W'(qest) * IDX_W'(LINE_BYTES);
    rem_full = o1 - qd;
    rem = rem_full[LB_W:0];
    if (rem >= (LB_W + 1)'(LINE_BYTES)) begin
      line_next = qest + LINE_W'(1);
      in_line_next = LB_W'(rem - (LB_W + 1)'(LINE_BYTES));
    end else begin
      line_next = qest;
      in_line_next = rem[LB_W-1:0];
    end
  end

  always_comb begin
    past_next = ({1'b0, line} >= (LINE_W + 1)'(TOTAL_LINES));
    y = LINE_W'(TOTAL_LINES - 1) - line;
    table_next = (y >= LINE_W'(TABLE_LINES));
    if (table_next) begin
      r_next = R_W'(y - LINE_W'(TABLE_LINES));
    end else begin
      r_next = R_W'(y);
    end
  end

  assign tile_sum = IDX_W'(in_line3 >> 2) + IDX_W'(r3[R_W-1:3]) * IDX_W'(LINE_TILES);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld1 <= (func == FUNC_LOAD);
      sa1 <= src_addr;
      sb1 <= src_byte;
      o1 <= out_index;
      qest <= prod[DIV_SHIFT+LINE_W-1:DIV_SHIFT];

      ld2 <= ld1;
      sa2 <= sa1;
      sb2 <= sb1;
      line <= line_next;
      in_line2 <= in_line_next;

      ld3 <= ld2;
      sa3 <= sa2;
      sb3 <= sb2;
      past3 <= past_next;
      tbl3 <= table_next;
      r3 <= r_next;
      in_line3 <= in_line2;

      // A plane-0 byte always has address bit 3 clear, its plane-1 partner set.
      ld4 <= ld3;
      sb4 <= sb3;
      sel4 <= in_line3[1:0];
      blank4 <= past3;
      if (ld3) begin
        row4 <= {sa3[12:4], sa3[2:0]};
        bank4 <= sa3[3];
      end else begin
        row4 <= {tbl3, tile_sum[7:0], r3[2:0]};
        bank4 <= 1'b0;
      end
    end
  end

  assign req.valid = v4;
  assign req.load = ld4;
  assign req.bank = bank4;
  assign req.row = row4;
  assign req.data = sb4;
  assign req.pair_sel = sel4;
  assign req.blank = blank4;

endmodule

// File: hw/rtl/ctbc_store.sv
// Pattern store split into two banks on address bit 3, one read of each per beat.
module ctbc_store
  import ctbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  mem_req_t req,
  output rd_data_t rd
);

  localparam int BANK_DEPTH = 1 << ROW_W;

  logic [BYTE_W-1:0] bank0 [BANK_DEPTH];
  logic [BYTE_W-1:0] bank1 [BANK_DEPTH];
  logic [BYTE_W-1:0] q0;
  logic [BYTE_W-1:0] q1;
  logic              v;
  logic [SEL_W-1:0]  sel;
  logic              blank;

  always_ff @(posedge clk) begin
    if (en) begin
      if (req.valid && req.load && !req.bank) begin
        bank0[req.row] <= req.data;
      end
      q0 <= bank0[req.row];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (req.valid && req.load && req.bank) begin
        bank1[req.row] <= req.data;
      end
      q1 <= bank1[req.row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= req.valid && !req.load;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel <= req.pair_sel;
      blank <= req.blank;
    end
  end

  assign rd.valid = v;
  assign rd.plane0 = q0;
  assign rd.plane1 = q1;
  assign rd.pair_sel = sel;
  assign rd.blank = blank;

endmodule

// File: hw/rtl/ctbc_out_buf.sv
// Pixel pair assembly, output register and skid register.
`include "chr_tile_to_bitmap_converter_macros.svh"
module ctbc_out_buf
  import ctbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rd_data_t          rd,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [BYTE_W-1:0] pixel_pair,
  output logic              hold
);

  logic [2:0]        li;
  logic [2:0]        ri;
  logic [BYTE_W-1:0] pair;
  logic              skid_valid;
  logic [BYTE_W-1:0] skid_pair;
  logic              new_beat;

  always_comb begin
    li = 3'd7 - {rd.pair_sel, 1'b0};
    ri = li - 3'd1;
    if (rd.blank) begin
      pair = '0;
    end else begin
      pair = {2'b00, rd.plane0[li], rd.plane1[li], 2'b00, rd.plane0[ri], rd.plane1[ri]};
    end
  end

  assign new_beat = en && rd.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (new_beat) begin
      if (out_valid && out_stall) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        pixel_pair <= skid_pair;
      end
    end else if (new_beat) begin
      if (out_valid && out_stall) begin
        skid_pair <= pair;
      end else begin
        pixel_pair <= pair;
      end
    end
  end

  assign hold = skid_valid;

  `CTBC_ASSERT_NOW(a_skid_implies_out, skid_valid, out_valid, "skid full while output empty")
  `CTBC_ASSERT_NEXT(a_skid_fill, new_beat && out_valid && out_stall, skid_valid, "blocked beat not kept in skid")
  `CTBC_ASSERT_NEXT(a_skid_drain, skid_valid && !out_stall, !skid_valid && out_valid, "skid not drained into output")
  `CTBC_ASSERT_NOW(a_pad_bits_zero, out_valid, pixel_pair[7:6] == 2'b00 && pixel_pair[3:2] == 2'b00, "pixel pair pad bits set")

endmodule
